FILE: hdl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared constants, types and helpers for the count-min sketch block.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int unsigned ROWS_DEF    = 4;
  localparam int unsigned COLUMNS_DEF = 1024;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned CNT_W  = 31;
  localparam int unsigned KEY_W  = 8;

  // 64-bit FNV-1a offset basis; the prime is 2^40 + 2^8 + 0xB3
  localparam logic [HASH_W-1:0] HASH_BASIS   = 64'hCBF29CE484222325;
  localparam logic [7:0]        MULT_LO      = 8'hB3;
  localparam int unsigned       PRIME_SH_MID = 8;
  localparam int unsigned       PRIME_SH_HI  = 40;
  localparam int unsigned       SEED_STEP    = 31;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // column unit: pipeline depth in cycles (fold, quotient, subtract, correct)
  localparam int unsigned MOD_STEPS = 4;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_MOD,
    ST_READ,
    ST_WRITE,
    ST_MIN
  } cms_state_e;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic hash_add;
    logic mod_init;
    logic mod_step;
    logic mem_rd;
    logic mem_wr;
    logic min_init;
    logic min_step;
    logic emit;
  } cms_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic min_last;
    logic last_q;
    logic mode_q;
  } cms_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hdl/cms_lane.sv
// ----------------------------------------------------------------------------
// cms_lane
// One sketch row: running FNV-1a hash, pipelined column remainder and
// the row's counter memory.
// ----------------------------------------------------------------------------
module cms_lane #(
  parameter int unsigned COLUMNS = 1024,
  parameter int unsigned ROW_IDX = 0,
  parameter int unsigned COL_W   = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cms_pkg::cms_cmd_t        cmd_i,
  input  logic [7:0]               key_byte_i,
  input  logic [COL_W-1:0]         clr_addr_i,
  output logic [cms_pkg::CNT_W-1:0] rd_data_o
);
  import cms_pkg::*;

  localparam int unsigned REM_W      = COL_W + 1;
  // byte-weighted fold of the hash stays below 2^FOLD_W for COLUMNS <= 65536
  localparam int unsigned FOLD_W     = 27;
  localparam int unsigned RECIP_W    = FOLD_W + 1;
  localparam int unsigned QM_W       = FOLD_W + RECIP_W;
  localparam int unsigned HASH_BYTES = HASH_W / 8;
  localparam logic [HASH_W-1:0] SEED = HASH_BASIS + HASH_W'(SEED_STEP * ROW_IDX);
  localparam logic [63:0] COLS64 = 64'(COLUMNS);
  // 2^(8*i) mod COLUMNS, one 16-bit weight per hash byte, byte 0 lowest
  localparam logic [HASH_BYTES*16-1:0] BYTE_WT = {
    16'(64'h0100_0000_0000_0000 % COLS64),
    16'(64'h0001_0000_0000_0000 % COLS64),
    16'(64'h0000_0100_0000_0000 % COLS64),
    16'(64'h0000_0001_0000_0000 % COLS64),
    16'(64'h0000_0000_0100_0000 % COLS64),
    16'(64'h0000_0000_0001_0000 % COLS64),
    16'(64'h0000_0000_0000_0100 % COLS64),
    16'(64'h0000_0000_0000_0001 % COLS64)
  };
  // floor(2^FOLD_W / COLUMNS); the quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << FOLD_W) / COLS64);

  logic [HASH_W-1:0]   h_q;
  logic [HASH_W-1:0]   x_q;
  logic [HASH_W-1:0]   prod_q;
  logic [HASH_W-1:0]   sh_q;
  logic [FOLD_W-1:0]   fold_q, fold_d;
  logic [FOLD_W-1:0]   y_q;
  logic [QM_W-1:0]     qm;
  logic [RECIP_W-1:0]  quo_q;
  logic [RECIP_W-1:0]  qc;
  logic [RECIP_W-1:0]  diff;
  logic [REM_W-1:0]    rem2_q, rem2_d;
  logic [REM_W-1:0]    rem_sub;
  logic [COL_W-1:0]    rem_q, rem_d;
  logic [HASH_W-1:0]   x;
  logic [HASH_W+7:0]   prod_full;
  logic [HASH_W-1:0]   sum;
  logic [CNT_W-1:0]    mem [COLUMNS];
  logic [CNT_W-1:0]    rd_q;
  logic                we;
  logic [COL_W-1:0]    waddr;
  logic [CNT_W-1:0]    wdata;

  assign x         = h_q ^ {{(HASH_W-KEY_W){1'b0}}, key_byte_i};
  assign prod_full = x * MULT_LO;
  assign sum       = prod_q + (x_q << PRIME_SH_MID) + (x_q << PRIME_SH_HI);

  // fold the hash bytes with their weights: same residue, far fewer bits
  always_comb begin
    logic [23:0] part;
    part   = '0;
    fold_d = '0;
    for (int i = 0; i < HASH_BYTES; i++) begin
      part   = {16'b0, sh_q[8*i +: 8]} * {8'b0, BYTE_WT[16*i +: 16]};
      fold_d = fold_d + {{(FOLD_W-24){1'b0}}, part};
    end
  end

  // reciprocal quotient, subtract, then one correcting subtract
  assign qm      = {{(QM_W-FOLD_W){1'b0}}, fold_q} * {{(QM_W-RECIP_W){1'b0}}, RECIP};
  assign qc      = quo_q * RECIP_W'(COLUMNS);
  assign diff    = {1'b0, y_q} - qc;
  assign rem2_d  = diff[REM_W-1:0];
  assign rem_sub = rem2_q - REM_W'(COLUMNS);
  assign rem_d   = (rem2_q >= REM_W'(COLUMNS)) ? rem_sub[COL_W-1:0] : rem2_q[COL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= SEED;
    end else if (cmd_i.mod_init) begin
      h_q <= SEED;
    end else if (cmd_i.hash_add) begin
      h_q <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_q <= prod_full[HASH_W-1:0];
      x_q    <= x;
    end
    if (cmd_i.mod_init) begin
      sh_q <= sum;
    end
    if (cmd_i.mod_step) begin
      fold_q <= fold_d;
      y_q    <= fold_q;
      quo_q  <= qm[QM_W-1:FOLD_W];
      rem2_q <= rem2_d;
      rem_q  <= rem_d;
    end
  end

  assign we    = cmd_i.clr_step | cmd_i.mem_wr;
  assign waddr = cmd_i.clr_step ? clr_addr_i : rem_q;
  assign wdata = cmd_i.clr_step ? '0 : sat_inc(rd_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[rem_q];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: hdl/cms_dp.sv
// ----------------------------------------------------------------------------
// cms_dp
// Datapath: row lanes, step counters, minimum search and result register.
// ----------------------------------------------------------------------------
module cms_dp #(
  parameter int unsigned ROWS    = 4,
  parameter int unsigned COLUMNS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cms_pkg::cms_cmd_t         cmd_i,
  output cms_pkg::cms_sts_t         sts_o,
  input  logic                      mode_i,
  input  logic [7:0]                key_byte_i,
  input  logic                      last_byte_i,
  output logic                      valid_o,
  output logic [cms_pkg::CNT_W-1:0] estimate_o
);
  import cms_pkg::*;

  localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [COL_W-1:0]     clr_addr_q;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [ROW_W-1:0]     row_q;
  logic [CNT_W-1:0]     min_q;
  logic                 mode_q, last_q, valid_q;
  logic [CNT_W-1:0]     rd [ROWS];

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    cms_lane #(
      .COLUMNS (COLUMNS),
      .ROW_IDX (r),
      .COL_W   (COL_W)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .key_byte_i (key_byte_i),
      .clr_addr_i (clr_addr_q),
      .rd_data_o  (rd[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      mod_cnt_q  <= '0;
      row_q      <= '0;
      mode_q     <= 1'b0;
      last_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.load) begin
        mode_q <= mode_i;
        last_q <= last_byte_i;
      end
      if (cmd_i.mod_init) begin
        mod_cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + 1'b1;
      end
      if (cmd_i.min_init) begin
        row_q <= '0;
      end else if (cmd_i.min_step) begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.min_init) begin
      min_q <= CNT_MAX;
    end else if (cmd_i.min_step && (rd[row_q] < min_q)) begin
      min_q <= rd[row_q];
    end
  end

  assign sts_o.clr_last = (clr_addr_q == COL_W'(COLUMNS - 1));
  assign sts_o.mod_last = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
  assign sts_o.min_last = (row_q == ROW_W'(ROWS - 1));
  assign sts_o.last_q   = last_q;
  assign sts_o.mode_q   = mode_q;

  assign valid_o    = valid_q;
  assign estimate_o = min_q;

endmodule

FILE: hdl/cms_ctrl.sv
// ----------------------------------------------------------------------------
// cms_ctrl
// Controller: sequences clearing, hashing, column selection and counter
// access for the datapath.
// ----------------------------------------------------------------------------
module cms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cms_pkg::cms_sts_t sts_i,
  output cms_pkg::cms_cmd_t cmd_o
);
  import cms_pkg::*;

  cms_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_ADD;
      ST_ADD:   state_d = sts_i.last_q ? ST_MOD : ST_IDLE;
      ST_MOD:   if (sts_i.mod_last) state_d = ST_READ;
      ST_READ:  state_d = (sts_i.mode_q == MODE_QUERY) ? ST_MIN : ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      ST_MIN:   if (sts_i.min_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_ADD: begin
        cmd_o.hash_add = 1'b1;
        cmd_o.mod_init = sts_i.last_q;
      end
      ST_MOD:   cmd_o.mod_step = 1'b1;
      ST_READ: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.min_init = 1'b1;
      end
      ST_WRITE: cmd_o.mem_wr = (sts_i.mode_q == MODE_ADD);
      ST_MIN: begin
        cmd_o.min_step = 1'b1;
        cmd_o.emit     = sts_i.min_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: hdl/count_min_sketch_fnv.sv
// ----------------------------------------------------------------------------
// count_min_sketch_fnv
// Count-min sketch with a seeded 64-bit FNV-1a hash per row, fed one key
// byte per transaction; adds bump saturating counters, queries return the
// minimum over rows.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   -------   ---------  ----------------------  ------------------------------
//   command   in         start_i && !busy_o      mode_i, key_byte_i, last_byte_i
//   result    out        valid_o (one cycle)     estimate_o
//
// Sequence: a byte that is not the last is accepted, then the shift-add
//   fold of the FNV prime is applied. A last byte then passes through the
//   column unit (byte fold, reciprocal quotient, subtract, correction), a
//   memory read, and either a counter write (add) or a minimum search over
//   all ROWS rows (query, result strobed the cycle after).
// Reset: all rows' hashes return to their seeds at once; the counter
//   memories are then swept to zero, one column per cycle in all rows at
//   once, with busy_o high.
// Stalls: the receiver cannot stall; busy_o holds off the sender only.
// ----------------------------------------------------------------------------
module count_min_sketch_fnv #(
  parameter int unsigned ROWS    = cms_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      mode_i,
  input  logic [7:0]                key_byte_i,
  input  logic                      last_byte_i,
  output logic                      valid_o,
  output logic [cms_pkg::CNT_W-1:0] estimate_o
);
  import cms_pkg::*;

  cms_cmd_t cmd;
  cms_sts_t sts;

  // Sequence each transaction: clear after reset, hash, reduce, access.
  cms_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Hold the per-row hashes and counters; drive the result strobe.
  cms_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (mode_i),
    .key_byte_i  (key_byte_i),
    .last_byte_i (last_byte_i),
    .valid_o     (valid_o),
    .estimate_o  (estimate_o)
  );

endmodule
